>>> hdl/mtimer_pkg.sv
// ----------------------------------------------------------------------------
// mtimer_pkg
// Types and constants for the machine timer with software interrupt.
// ----------------------------------------------------------------------------
package mtimer_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned COUNT_W  = 64;
    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned INDEX_W  = 3;

    localparam logic [DATA_W-1:0] WORD_ONES  = 32'hFFFF_FFFF;
    localparam int unsigned       RST_BIT    = 31;
    localparam int unsigned       SOFT_BIT   = 0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef enum logic [INDEX_W-1:0] {
        REG_CNT_LO  = 3'd0,
        REG_CNT_HI  = 3'd1,
        REG_CMP_LO  = 3'd2,
        REG_CMP_HI  = 3'd3,
        REG_SOFTRST = 3'd4,
        REG_CTL     = 3'd5,
        REG_SOFTIRQ = 3'd6,
        REG_UNUSED  = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              timer_int;
        logic              sw_int;
    } result_t;

endpackage

>>> hdl/machine_timer_with_soft_interrupt.sv
// ----------------------------------------------------------------------------
// machine_timer_with_soft_interrupt
// 64-bit machine timer with compare and software interrupt behind seven
// 32-bit registers, driven by a stream of tick, read and write words.
// ----------------------------------------------------------------------------
//  Channel  | Ports                                   | Direction
//  ---------+-----------------------------------------+----------
//  input    | s_valid s_ready s_func s_reg_index      | in
//           | s_write_data                            |
//  result   | m_valid m_ready m_read_data m_timer_int | out
//           | m_sw_int                                |
//
// One word is taken per cycle while s_ready is high; its result is registered
// in the output register. The counter increment and the 64-bit compare form
// the longest path. A skid register holds a second result while the output is
// stalled, so s_ready drops only when both are full. Reset (aresetn low) sets
// compare to all ones, clears the rest and empties both result registers.
// ----------------------------------------------------------------------------
module machine_timer_with_soft_interrupt (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [mtimer_pkg::FUNC_W-1:0]       s_func,
    input  logic [mtimer_pkg::INDEX_W-1:0]      s_reg_index,
    input  logic [mtimer_pkg::DATA_W-1:0]       s_write_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [mtimer_pkg::DATA_W-1:0]       m_read_data,
    output logic                                m_timer_int,
    output logic                                m_sw_int
);

    logic [mtimer_pkg::COUNT_W-1:0] time_count_reg, time_count_next;
    logic [mtimer_pkg::COUNT_W-1:0] compare_reg, compare_next;
    logic [mtimer_pkg::DATA_W-1:0]  control_reg, control_next;
    logic [mtimer_pkg::DATA_W-1:0]  soft_reg, soft_next;

    mtimer_pkg::result_t out_reg, skid_reg, result_next;
    logic                out_valid_reg, skid_valid_reg;

    logic accept_in;
    logic take_out;
    mtimer_pkg::func_t      func;
    mtimer_pkg::reg_index_t index;

    assign func      = mtimer_pkg::func_t'(s_func);
    assign index     = mtimer_pkg::reg_index_t'(s_reg_index);
    assign s_ready   = !skid_valid_reg;
    assign accept_in = s_valid && s_ready;
    assign take_out  = out_valid_reg && m_ready;

    // Next timer state and the result word for the incoming item.
    always_comb begin
        time_count_next = time_count_reg;
        compare_next    = compare_reg;
        control_next    = control_reg;
        soft_next       = soft_reg;
        result_next.read_data = '0;
        unique case (func)
            mtimer_pkg::FUNC_TICK: begin
                time_count_next = time_count_reg + 64'd1;
            end
            mtimer_pkg::FUNC_READ: begin
                unique case (index)
                    mtimer_pkg::REG_CNT_LO:  result_next.read_data = time_count_reg[31:0];
                    mtimer_pkg::REG_CNT_HI:  result_next.read_data = time_count_reg[63:32];
                    mtimer_pkg::REG_CMP_LO:  result_next.read_data = compare_reg[31:0];
                    mtimer_pkg::REG_CMP_HI:  result_next.read_data = compare_reg[63:32];
                    mtimer_pkg::REG_CTL:     result_next.read_data = control_reg;
                    mtimer_pkg::REG_SOFTIRQ: result_next.read_data = soft_reg;
                    default:                 result_next.read_data = '0;
                endcase
            end
            mtimer_pkg::FUNC_WRITE: begin
                unique case (index)
                    mtimer_pkg::REG_CNT_LO: time_count_next[31:0]  = s_write_data;
                    mtimer_pkg::REG_CNT_HI: time_count_next[63:32] = s_write_data;
                    mtimer_pkg::REG_CMP_LO: begin
                        compare_next = {mtimer_pkg::WORD_ONES, s_write_data};
                    end
                    mtimer_pkg::REG_CMP_HI: compare_next[63:32] = s_write_data;
                    mtimer_pkg::REG_SOFTRST: begin
                        if (s_write_data[mtimer_pkg::RST_BIT]) begin
                            time_count_next = '0;
                            compare_next    = '1;
                            control_next    = '0;
                            soft_next       = '0;
                        end
                    end
                    mtimer_pkg::REG_CTL:     control_next = s_write_data;
                    mtimer_pkg::REG_SOFTIRQ: soft_next    = s_write_data;
                    default: ;
                endcase
            end
            default: ;
        endcase
        // Interrupt levels are reported as they stand after this item.
        result_next.timer_int = (time_count_next >= compare_next);
        result_next.sw_int    = soft_next[mtimer_pkg::SOFT_BIT];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_count_reg <= '0;
            compare_reg    <= '1;
            control_reg    <= '0;
            soft_reg       <= '0;
        end else if (accept_in) begin
            time_count_reg <= time_count_next;
            compare_reg    <= compare_next;
            control_reg    <= control_next;
            soft_reg       <= soft_next;
        end
    end

    // Output register with a skid stage behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || take_out) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= accept_in;
                end
            end else if (accept_in) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || take_out) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept_in) begin
                out_reg <= result_next;
            end
        end else if (accept_in) begin
            skid_reg <= result_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_read_data = out_reg.read_data;
    assign m_timer_int = out_reg.timer_int;
    assign m_sw_int    = out_reg.sw_int;

    // A result never sits in the skid stage while the output register is empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // A tick advances the counter by exactly one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept_in && func == mtimer_pkg::FUNC_TICK)
        |=> time_count_reg == $past(time_count_reg) + 64'd1)
        else $error("tick did not advance the counter by one");

    // A compare-low write forces the upper compare half to all ones.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept_in && func == mtimer_pkg::FUNC_WRITE && index == mtimer_pkg::REG_CMP_LO)
        |=> compare_reg[63:32] == mtimer_pkg::WORD_ONES)
        else $error("compare-low write left upper compare half changed");

    // A soft-reset write with the reset bit restores the reset state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept_in && func == mtimer_pkg::FUNC_WRITE && index == mtimer_pkg::REG_SOFTRST
            && s_write_data[mtimer_pkg::RST_BIT])
        |=> (time_count_reg == '0 && compare_reg == '1 && control_reg == '0
            && soft_reg == '0))
        else $error("soft reset did not restore the reset state");

    // Input stalls only once a stalled result has been parked in the skid stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(out_valid_reg && !m_ready && accept_in))
        else $error("input stalled without a parked result");

endmodule

>>> tb/sv/machine_timer_with_soft_interrupt_tb.sv
// ----------------------------------------------------------------------------
// machine_timer_with_soft_interrupt_tb
// Self-checking bench for the machine timer. A directed block covers reset
// values, every register, counter wrap and the soft-reset rules. Random runs
// that set counter and compare close together and then tick across the
// boundary follow, mixed with noise words. Both channels idle at random. A
// timer model predicts every result word, and the bench compares each
// field of every result with its prediction.
// ----------------------------------------------------------------------------
module machine_timer_with_soft_interrupt_tb;

    typedef struct packed {
        mtimer_pkg::func_t                 func;
        mtimer_pkg::reg_index_t            idx;
        logic [mtimer_pkg::DATA_W-1:0]     data;
    } bus_word_t;

    logic                           aclk         = 1'b0;
    logic                           aresetn      = 1'b0;
    logic                           s_valid      = 1'b0;
    logic                           s_ready;
    logic [mtimer_pkg::FUNC_W-1:0]  s_func       = '0;
    logic [mtimer_pkg::INDEX_W-1:0] s_reg_index  = '0;
    logic [mtimer_pkg::DATA_W-1:0]  s_write_data = '0;
    logic                           m_valid;
    logic                           m_ready      = 1'b0;
    logic [mtimer_pkg::DATA_W-1:0]  m_read_data;
    logic                           m_timer_int;
    logic                           m_sw_int;

    // Timer model state, starting from the reset values.
    logic [mtimer_pkg::COUNT_W-1:0] count_model   = '0;
    logic [mtimer_pkg::COUNT_W-1:0] compare_model = '1;
    logic [mtimer_pkg::DATA_W-1:0]  control_model = '0;
    logic [mtimer_pkg::DATA_W-1:0]  soft_model    = '0;

    bus_word_t           pending_words[$];
    mtimer_pkg::result_t expected_results[$];
    bus_word_t           driven_word;

    int accepted_count = 0;
    int mismatch_count = 0;
    int tick_count     = 0;
    int read_count     = 0;
    int write_count    = 0;
    int other_count    = 0;
    int irq_high_count = 0;
    int result_count   = 0;

    logic calm_stretch;
    assign calm_stretch = (accepted_count >= 400) && (accepted_count < 650);

    machine_timer_with_soft_interrupt uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_reg_index  (s_reg_index),
        .s_write_data (s_write_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .m_timer_int  (m_timer_int),
        .m_sw_int     (m_sw_int)
    );

    always #5 aclk = ~aclk;

    // Applies one word to the timer model and returns the result it causes.
    task automatic run_timer_model(input bus_word_t w, output mtimer_pkg::result_t r);
        logic [mtimer_pkg::DATA_W-1:0] rd;
        rd = '0;
        case (w.func)
            mtimer_pkg::FUNC_TICK: begin
                count_model = count_model + 64'd1;
                tick_count++;
            end
            mtimer_pkg::FUNC_READ: begin
                read_count++;
                case (w.idx)
                    mtimer_pkg::REG_CNT_LO:  rd = count_model[31:0];
                    mtimer_pkg::REG_CNT_HI:  rd = count_model[63:32];
                    mtimer_pkg::REG_CMP_LO:  rd = compare_model[31:0];
                    mtimer_pkg::REG_CMP_HI:  rd = compare_model[63:32];
                    mtimer_pkg::REG_CTL:     rd = control_model;
                    mtimer_pkg::REG_SOFTIRQ: rd = soft_model;
                    default:                 rd = '0;
                endcase
            end
            mtimer_pkg::FUNC_WRITE: begin
                write_count++;
                case (w.idx)
                    mtimer_pkg::REG_CNT_LO:  count_model[31:0] = w.data;
                    mtimer_pkg::REG_CNT_HI:  count_model[63:32] = w.data;
                    mtimer_pkg::REG_CMP_LO:  compare_model = {mtimer_pkg::WORD_ONES, w.data};
                    mtimer_pkg::REG_CMP_HI:  compare_model[63:32] = w.data;
                    mtimer_pkg::REG_SOFTRST: begin
                        if (w.data[mtimer_pkg::RST_BIT]) begin
                            count_model   = '0;
                            compare_model = '1;
                            control_model = '0;
                            soft_model    = '0;
                        end
                    end
                    mtimer_pkg::REG_CTL:     control_model = w.data;
                    mtimer_pkg::REG_SOFTIRQ: soft_model = w.data;
                    default: ;
                endcase
            end
            default: other_count++;
        endcase
        r.read_data = rd;
        r.timer_int = (count_model >= compare_model);
        r.sw_int    = soft_model[mtimer_pkg::SOFT_BIT];
    endtask

    // Driver: presents queued words, holding each until it is accepted.
    always @(posedge aclk) begin
        mtimer_pkg::result_t predicted;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                run_timer_model(driven_word, predicted);
                expected_results.push_back(predicted);
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                if (pending_words.size() != 0 &&
                    (calm_stretch || $urandom_range(99) >= 35)) begin
                    driven_word = pending_words.pop_front();
                    s_valid      <= 1'b1;
                    s_func       <= driven_word.func;
                    s_reg_index  <= driven_word.idx;
                    s_write_data <= driven_word.data;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(input string field,
                                   input logic [mtimer_pkg::DATA_W-1:0] exp_v,
                                   input logic [mtimer_pkg::DATA_W-1:0] act_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("Mismatch in %s at result %0d: expected %h, got %h",
                     field, result_count, exp_v, act_v);
    endtask

    // Monitor: checks every accepted result word against the oldest prediction.
    always @(posedge aclk) begin
        mtimer_pkg::result_t exp_r;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected result word: read_data %h", m_read_data);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_read_data !== exp_r.read_data)
                        report_mismatch("read_data", exp_r.read_data, m_read_data);
                    if (m_timer_int !== exp_r.timer_int)
                        report_mismatch("timer_int", 32'(exp_r.timer_int),
                                        32'(m_timer_int));
                    if (m_sw_int !== exp_r.sw_int)
                        report_mismatch("sw_int", 32'(exp_r.sw_int), 32'(m_sw_int));
                    if (exp_r.timer_int)
                        irq_high_count++;
                end
                result_count++;
            end
            m_ready <= calm_stretch || ($urandom_range(99) >= 35);
        end
    end

    task automatic push_word(input mtimer_pkg::func_t f, input mtimer_pkg::reg_index_t i,
                             input logic [mtimer_pkg::DATA_W-1:0] d);
        bus_word_t w;
        w.func = f;
        w.idx  = i;
        w.data = d;
        pending_words.push_back(w);
    endtask

    // Sets counter and compare up to eight counts apart (the compare high write is
    // skipped at random), then ticks around the boundary with reads mixed in.
    task automatic push_compare_run();
        logic [mtimer_pkg::COUNT_W-1:0] base;
        logic [mtimer_pkg::COUNT_W-1:0] cmp;
        int                             offset;
        int                             mode;
        int                             n_ticks;
        base = {$urandom, $urandom};
        mode = $urandom_range(3);
        if (mode == 1)
            base[31:0] = 32'hFFFF_FFF0 | $urandom_range(15);
        else if (mode == 2)
            base = {mtimer_pkg::WORD_ONES, 32'hFFFF_FFF0 | $urandom_range(15)};
        offset = $urandom_range(8);
        cmp = $urandom_range(1) ? base + 64'(offset) : base - 64'(offset);
        push_word(mtimer_pkg::FUNC_WRITE, mtimer_pkg::REG_CNT_LO, base[31:0]);
        push_word(mtimer_pkg::FUNC_WRITE, mtimer_pkg::REG_CNT_HI, base[63:32]);
        push_word(mtimer_pkg::FUNC_WRITE, mtimer_pkg::REG_CMP_LO, cmp[31:0]);
        if ($urandom_range(3) != 0)
            push_word(mtimer_pkg::FUNC_WRITE, mtimer_pkg::REG_CMP_HI, cmp[63:32]);
        if ($urandom_range(2) == 0)
            push_word(mtimer_pkg::FUNC_WRITE, mtimer_pkg::REG_SOFTIRQ, $urandom);
        n_ticks = $urandom_range(12);
        for (int k = 0; k < n_ticks; k++) begin
            push_word(mtimer_pkg::FUNC_TICK,
                      mtimer_pkg::reg_index_t'($urandom_range(7)), $urandom);
            if ($urandom_range(9) < 3)
                push_word(mtimer_pkg::FUNC_READ,
                          mtimer_pkg::reg_index_t'($urandom_range(7)), $urandom);
        end
    endtask

    initial begin
        int n_noise;
        // Reset values of every register, including the unused index.
        for (int i = 0; i < 8; i++)
            push_word(mtimer_pkg::FUNC_READ, mtimer_pkg::reg_index_t'(i), 32'h0);
        push_word(mtimer_pkg::FUNC_TICK, mtimer_pkg::REG_CNT_LO, 32'hFFFF_FFFF);
        // Compare-low write forces the high half to all ones.
        push_word(mtimer_pkg::FUNC_WRITE, mtimer_pkg::REG_CMP_LO, 32'h0000_0003);
        push_word(mtimer_pkg::FUNC_READ, mtimer_pkg::REG_CMP_HI, 32'h0);
        push_word(mtimer_pkg::FUNC_WRITE, mtimer_pkg::REG_CMP_HI, 32'h0);
        push_word(mtimer_pkg::FUNC_TICK, mtimer_pkg::REG_CNT_LO, 32'h0);
        push_word(mtimer_pkg::FUNC_TICK, mtimer_pkg::REG_CNT_LO, 32'h0);
        push_word(mtimer_pkg::FUNC_WRITE, mtimer_pkg::REG_SOFTIRQ, 32'hFFFF_FFFF);
        push_word(mtimer_pkg::FUNC_WRITE, mtimer_pkg::REG_CTL, 32'hA5A5_5A5A);
        push_word(mtimer_pkg::FUNC_READ, mtimer_pkg::REG_CTL, 32'h0);
        push_word(mtimer_pkg::FUNC_WRITE, mtimer_pkg::REG_SOFTIRQ, 32'h0000_0002);
        // Soft reset without bit 31 does nothing; its read is always zero.
        push_word(mtimer_pkg::FUNC_WRITE, mtimer_pkg::REG_SOFTRST, 32'h7FFF_FFFF);
        push_word(mtimer_pkg::FUNC_READ, mtimer_pkg::REG_SOFTRST, 32'h0);
        // Counter wraps from all ones to zero.
        push_word(mtimer_pkg::FUNC_WRITE, mtimer_pkg::REG_CNT_HI, 32'hFFFF_FFFF);
        push_word(mtimer_pkg::FUNC_WRITE, mtimer_pkg::REG_CNT_LO, 32'hFFFF_FFFF);
        push_word(mtimer_pkg::FUNC_TICK, mtimer_pkg::REG_CNT_LO, 32'h0);
        push_word(mtimer_pkg::FUNC_READ, mtimer_pkg::REG_CNT_HI, 32'h0);
        push_word(mtimer_pkg::FUNC_NOP, mtimer_pkg::REG_UNUSED, 32'hFFFF_FFFF);
        push_word(mtimer_pkg::FUNC_WRITE, mtimer_pkg::REG_UNUSED, 32'hFFFF_FFFF);
        push_word(mtimer_pkg::FUNC_WRITE, mtimer_pkg::REG_SOFTRST, 32'h8000_0000);
        push_word(mtimer_pkg::FUNC_READ, mtimer_pkg::REG_CMP_LO, 32'h0);

        while (pending_words.size() < 1100) begin
            if ($urandom_range(99) < 70) begin
                push_compare_run();
            end else begin
                n_noise = $urandom_range(1, 5);
                for (int k = 0; k < n_noise; k++)
                    push_word(mtimer_pkg::func_t'($urandom_range(3)),
                              mtimer_pkg::reg_index_t'($urandom_range(7)), $urandom);
                if ($urandom_range(4) == 0)
                    push_word(mtimer_pkg::FUNC_WRITE, mtimer_pkg::REG_SOFTRST,
                              ($urandom_range(1) << mtimer_pkg::RST_BIT)
                              | ($urandom & 32'h7FFF_FFFF));
            end
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_words.size() == 0 && !s_valid);
        wait (expected_results.size() == 0);
        repeat (20) @(posedge aclk);

        $display("Checked %0d results: %0d ticks, %0d reads, %0d writes, %0d no-op words.",
                 result_count, tick_count, read_count, write_count, other_count);
        $display("Timer interrupt was high in %0d of them.", irq_high_count);
        if (mismatch_count == 0) begin
            $display("machine_timer_with_soft_interrupt test passed");
        end else begin
            $display("%0d mismatches in total.", mismatch_count);
            $display("machine_timer_with_soft_interrupt test failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timed out with %0d words pending and %0d results outstanding.",
                 pending_words.size(), expected_results.size());
        $display("machine_timer_with_soft_interrupt test failed");
        $finish;
    end

endmodule
